@@ hdl/bcl_pkg.sv @@
// Shared types, constants and frame tables of the button code lock.
package bcl_pkg;

   localparam int TIMER_BITS_DEFAULT = 24;
   localparam int CSR_DATA_W         = 24;
   localparam int CSR_INDEX_W        = 2;
   localparam int CODE_W             = 13;
   localparam int RETRY_W            = 2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CORRECT_CODE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_TICKS     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALLOWED_RETRIES = 2'd2;

   // Register reset values
   localparam logic [CODE_W-1:0]     CODE_RESET        = 13'd1234;
   localparam logic [CSR_DATA_W-1:0] FRAME_TICKS_RESET = 24'd100000;
   localparam logic [RETRY_W-1:0]    RETRIES_RESET     = 2'd2;

   // Request opcodes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_PRESS = 1'b1;

   localparam logic [3:0] ALL_PRESSED  = 4'hF;
   localparam logic [2:0] VICTORY_LEN  = 3'd6;
   localparam logic [2:0] VICTORY_LAST = 3'd5;
   localparam logic [4:0] ERROR_SHOWS  = 5'd16;

   typedef enum logic [1:0] {
      MODE_ENTER  = 2'd0,
      MODE_ERROR  = 2'd1,
      MODE_OPEN   = 2'd2,
      MODE_LOCKED = 2'd3
   } mode_type;

   typedef struct packed {
      logic       opcode;
      logic [1:0] button;
   } req_type;

   typedef struct packed {
      logic [3:0] leds;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [CODE_W-1:0]  correct_code;
      logic [RETRY_W-1:0] allowed_retries;
   } cfg_type;

   function automatic logic [3:0] victory_frame(input logic [2:0] idx);
      logic [3:0] f;
      case (idx)
         3'd0:    f = 4'h1;
         3'd1:    f = 4'h2;
         3'd2:    f = 4'h4;
         3'd3:    f = 4'h8;
         3'd4:    f = 4'h4;
         3'd5:    f = 4'h2;
         default: f = 4'h1;
      endcase
      return f;
   endfunction

   function automatic logic [3:0] error_frame(input logic [2:0] idx);
      logic [3:0] f;
      case (idx)
         3'd0:    f = 4'h0;
         3'd1:    f = 4'h8;
         3'd2:    f = 4'hC;
         3'd3:    f = 4'hE;
         3'd4:    f = 4'hF;
         3'd5:    f = 4'h7;
         3'd6:    f = 4'h3;
         default: f = 4'h1;
      endcase
      return f;
   endfunction

endpackage

@@ hdl/button_code_lock.sv @@
// An accepted request passes through the request register, then the response register,
//   from which it is offered as a response.
// Throughput: one request per cycle; a waiting response holds up requests only once the
//   request register behind it is full as well.
// Each request is done in one pass of the lock update between the two registers.
// Reset (synchronous, active high) empties both registers, loads the register defaults
//   and puts the lock in the entering mode with all LEDs off.
module button_code_lock #(
   parameter int TIMER_BITS = bcl_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bcl_pkg::req_type                req_data,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bcl_pkg::rsp_type                rsp_data,
   // configuration writes
   input  logic                            csr_wr_en,
   input  logic [bcl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bcl_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                  req_valid_ff;
   bcl_pkg::req_type      req_data_ff;
   logic                  rsp_valid_ff;
   bcl_pkg::rsp_type      rsp_data_ff;

   logic                  advance;
   logic                  step;
   bcl_pkg::cfg_type      cfg;
   logic [TIMER_BITS-1:0] frame_ticks;
   bcl_pkg::rsp_type      result;

   // The response register moves on when it is empty or being taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   // Hold the requester only while the request register is full and cannot drain.
   assign req_stall = req_valid_ff && !advance;
   // Apply the held request to the lock state as it moves into the response register.
   assign step      = req_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   // Response payload holds while stalled.
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   bcl_csr #(
      .TIMER_BITS (TIMER_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg),
      .frame_ticks (frame_ticks)
   );

   bcl_lock #(
      .TIMER_BITS (TIMER_BITS)
   ) u_lock (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (req_data_ff),
      .cfg         (cfg),
      .frame_ticks (frame_ticks),
      .result      (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/bcl_csr.sv @@
// Configuration registers of the button code lock.
module bcl_csr #(
   parameter int TIMER_BITS = bcl_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [bcl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bcl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output bcl_pkg::cfg_type                   cfg,
   output logic [TIMER_BITS-1:0]              frame_ticks
);

   logic [bcl_pkg::CODE_W-1:0]  correct_code_ff, correct_code_in;
   logic [TIMER_BITS-1:0]       frame_ticks_ff, frame_ticks_in;
   logic [bcl_pkg::RETRY_W-1:0] retries_ff, retries_in;

   always_comb begin
      correct_code_in = correct_code_ff;
      frame_ticks_in  = frame_ticks_ff;
      retries_in      = retries_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bcl_pkg::CSR_CORRECT_CODE: begin
               correct_code_in = csr_wdata[bcl_pkg::CODE_W-1:0];
            end
            bcl_pkg::CSR_FRAME_TICKS: begin
               frame_ticks_in = TIMER_BITS'(csr_wdata);
            end
            bcl_pkg::CSR_ALLOWED_RETRIES: begin
               retries_in = csr_wdata[bcl_pkg::RETRY_W-1:0];
            end
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         correct_code_ff <= bcl_pkg::CODE_RESET;
         frame_ticks_ff  <= TIMER_BITS'(bcl_pkg::FRAME_TICKS_RESET);
         retries_ff      <= bcl_pkg::RETRIES_RESET;
      end else begin
         correct_code_ff <= correct_code_in;
         frame_ticks_ff  <= frame_ticks_in;
         retries_ff      <= retries_in;
      end
   end

   assign cfg.correct_code    = correct_code_ff;
   assign cfg.allowed_retries = retries_ff;
   assign frame_ticks         = frame_ticks_ff;

endmodule

@@ hdl/bcl_lock.sv @@
// Lock state and the single-pass update for one request.
module bcl_lock #(
   parameter int TIMER_BITS = bcl_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  bcl_pkg::req_type      item,
   input  bcl_pkg::cfg_type      cfg,
   input  logic [TIMER_BITS-1:0] frame_ticks,
   output bcl_pkg::rsp_type      result
);

   bcl_pkg::mode_type            mode_ff, mode_in;
   logic [3:0]                   mask_ff, mask_in;
   logic [bcl_pkg::CODE_W-1:0]   code_ff, code_in;
   logic [1:0]                   mistakes_ff, mistakes_in;
   logic [2:0]                   frame_ff, frame_in;
   logic [4:0]                   shown_ff, shown_in;
   logic [TIMER_BITS-1:0]        tick_ff, tick_in;
   logic [3:0]                   led_ff, led_in;

   logic                         is_press;
   logic [3:0]                   press_bit;
   logic                         press_ok;
   logic [3:0]                   mask_new;
   logic [bcl_pkg::CODE_W-1:0]   code_new;
   logic [TIMER_BITS-1:0]        tick_inc;
   logic                         frame_due;
   logic [4:0]                   shown_inc;
   logic                         error_done;
   logic [2:0]                   vic_idx;

   assign is_press  = (item.opcode == bcl_pkg::OP_PRESS);
   assign press_bit = 4'b0001 << item.button;
   assign press_ok  = (mode_ff == bcl_pkg::MODE_ENTER) && ((mask_ff & press_bit) == 4'b0000);
   assign mask_new  = mask_ff | press_bit;
   // code * 10 as two shifts, plus the digit
   assign code_new  = {code_ff[bcl_pkg::CODE_W-4:0], 3'b000}
                    + {code_ff[bcl_pkg::CODE_W-2:0], 1'b0}
                    + {{(bcl_pkg::CODE_W-2){1'b0}}, item.button}
                    + {{(bcl_pkg::CODE_W-1){1'b0}}, 1'b1};

   assign tick_inc   = tick_ff + {{(TIMER_BITS-1){1'b0}}, 1'b1};
   assign frame_due  = !(tick_inc < frame_ticks);
   assign shown_inc  = shown_ff + 5'd1;
   assign error_done = (mode_ff == bcl_pkg::MODE_ERROR) && frame_due
                     && (shown_inc >= bcl_pkg::ERROR_SHOWS);
   assign vic_idx    = (frame_ff >= bcl_pkg::VICTORY_LEN) ? 3'd0 : frame_ff;

   // Next mode
   always_comb begin
      mode_in = mode_ff;
      if (step) begin
         unique case (mode_ff) inside
            bcl_pkg::MODE_ENTER: begin
               if (is_press && press_ok && (mask_new == bcl_pkg::ALL_PRESSED)) begin
                  if (code_new == cfg.correct_code) begin
                     mode_in = bcl_pkg::MODE_OPEN;
                  end else if (mistakes_ff < cfg.allowed_retries) begin
                     mode_in = bcl_pkg::MODE_ERROR;
                  end else begin
                     mode_in = bcl_pkg::MODE_LOCKED;
                  end
               end
            end
            bcl_pkg::MODE_ERROR: begin
               if (!is_press && error_done) begin
                  mode_in = bcl_pkg::MODE_ENTER;
               end
            end
            bcl_pkg::MODE_OPEN, bcl_pkg::MODE_LOCKED: begin
               mode_in = mode_ff;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   // Entry, counters and LED levels
   always_comb begin
      mask_in     = mask_ff;
      code_in     = code_ff;
      mistakes_in = mistakes_ff;
      frame_in    = frame_ff;
      shown_in    = shown_ff;
      tick_in     = tick_ff;
      led_in      = led_ff;
      if (step) begin
         if (is_press) begin
            if (press_ok) begin
               mask_in = mask_new;
               led_in  = led_ff | press_bit;
               code_in = code_new;
               if (mask_new == bcl_pkg::ALL_PRESSED) begin
                  frame_in = 3'd0;
                  shown_in = 5'd0;
                  tick_in  = '0;
               end
            end
         end else if (mode_ff != bcl_pkg::MODE_ENTER) begin
            tick_in = frame_due ? '0 : tick_inc;
            if (frame_due) begin
               if (mode_ff == bcl_pkg::MODE_OPEN) begin
                  led_in   = bcl_pkg::victory_frame(vic_idx);
                  frame_in = (vic_idx == bcl_pkg::VICTORY_LAST) ? 3'd0 : vic_idx + 3'd1;
               end else begin
                  led_in   = bcl_pkg::error_frame(frame_ff);
                  frame_in = frame_ff + 3'd1;
                  if (mode_ff == bcl_pkg::MODE_ERROR) begin
                     shown_in = shown_inc;
                  end
                  if (error_done) begin
                     mistakes_in = mistakes_ff + 2'd1;
                     code_in     = '0;
                     mask_in     = 4'b0000;
                     led_in      = 4'b0000;
                     shown_in    = 5'd0;
                     frame_in    = 3'd0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= bcl_pkg::MODE_ENTER;
         mask_ff     <= 4'b0000;
         code_ff     <= '0;
         mistakes_ff <= 2'd0;
         frame_ff    <= 3'd0;
         shown_ff    <= 5'd0;
         tick_ff     <= '0;
         led_ff      <= 4'b0000;
      end else begin
         mode_ff     <= mode_in;
         mask_ff     <= mask_in;
         code_ff     <= code_in;
         mistakes_ff <= mistakes_in;
         frame_ff    <= frame_in;
         shown_ff    <= shown_in;
         tick_ff     <= tick_in;
         led_ff      <= led_in;
      end
   end

   assign result.leds   = led_in;
   assign result.status = mode_in;

endmodule

@@ hdl/bcl_checker.sv @@
// Port-level checks of the button code lock and their binding.
module bcl_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bcl_pkg::rsp_type rsp_data
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // Every accepted request is followed by an offered response.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##2 rsp_valid)
      else $error("accepted request gave no response");

   // Unlocked and locked out are final until reset.
   a_final_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == bcl_pkg::MODE_OPEN
                     || rsp_data.status == bcl_pkg::MODE_LOCKED))
      |=> (!rsp_valid || rsp_data.status == $past(rsp_data.status)))
      else $error("lock left a final mode");

endmodule

bind button_code_lock bcl_checker u_bcl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ bench/testbench.sv @@
// Self-checking bench for the button code lock against a lock predictor.
`timescale 1ns / 1ps

module testbench;

   // Run shape
   localparam int ITEM_TARGET  = 1350;
   localparam int LIMIT_CYCLES = 500000;
   localparam int TAIL_CYCLES  = 8;

   // Animation frames, frame i in nibble i
   localparam logic [23:0] VICTORY_SEQ       = 24'h248421;
   localparam logic [31:0] ERROR_SEQ         = 32'h137FEC80;
   localparam logic [2:0]  VICTORY_WRAP      = 3'd5;
   localparam logic [4:0]  ERROR_FRAME_SHOWS = 5'd16;
   localparam logic [3:0]  EVERY_BUTTON      = 4'hF;

   // Register values of interest
   localparam logic [12:0] CODE_AT_RESET    = 13'd1234;
   localparam logic [23:0] TICKS_AT_RESET   = 24'd100000;
   localparam logic [1:0]  RETRIES_AT_RESET = 2'd2;
   localparam logic [12:0] CODE_TOP         = 13'd4444;
   localparam logic [12:0] CODE_ABOVE_RANGE = 13'h1FFF;
   localparam logic [23:0] TICKS_MAX        = 24'hFFFFFF;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   bcl_pkg::req_type                req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   bcl_pkg::rsp_type                rsp_data;
   logic                            csr_wr_en = 1'b0;
   logic [bcl_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bcl_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predicted configuration, mirrored on every register write
   logic [12:0] cfg_code        = CODE_AT_RESET;
   logic [23:0] cfg_frame_ticks = TICKS_AT_RESET;
   logic [1:0]  cfg_retries     = RETRIES_AT_RESET;

   // Predicted lock state
   logic [3:0]        lock_mask     = '0;
   logic [12:0]       lock_entry    = '0;
   logic [1:0]        lock_mistakes = '0;
   bcl_pkg::mode_type lock_mode     = bcl_pkg::MODE_ENTER;
   logic [2:0]        lock_frame    = '0;
   logic [4:0]        lock_shown    = '0;
   logic [23:0]       lock_ticks    = '0;
   logic [3:0]        lock_leds     = '0;

   // Lock views still owed by the block, oldest first
   bcl_pkg::rsp_type  lock_views [$];
   bcl_pkg::rsp_type  due_view;

   logic [1:0]  key_order [4];
   bit          valid_up    = 1'b0;
   int          burst_left  = 0;
   int          sent_count  = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          stall_left  = 0;
   int          stall_pick;

   button_code_lock u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Give up on a hung block; the limit is many times the slowest honest run.
   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("button_code_lock regression: fail");
      $finish;
   end

   // Response-side back-pressure: short stalls and short free runs mostly, now and then
   // a long stall or a long stretch with no stall at all.
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 45) begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(0, 6);
         end else if (stall_pick < 60) begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(20, 80);
         end else if (stall_pick < 95) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(10, 40);
         end
      end
   end

   // Compare every accepted response with the oldest predicted lock view.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (lock_views.size() == 0) begin
            $display("%0t: response leds %h status %0d with no request outstanding",
                     $time, rsp_data.leds, rsp_data.status);
            error_count++;
         end else begin
            due_view = lock_views.pop_front();
            if (rsp_data.leds !== due_view.leds) begin
               $display("%0t: leds expected %h, got %h", $time, due_view.leds, rsp_data.leds);
               error_count++;
            end
            if (rsp_data.status !== due_view.status) begin
               $display("%0t: status expected %0d, got %0d",
                        $time, due_view.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   function automatic logic [1:0] random_button();
      return 2'($urandom_range(0, 3));
   endfunction

   task automatic start_animation(input bcl_pkg::mode_type next_mode);
      lock_mode  = next_mode;
      lock_frame = '0;
      lock_shown = '0;
      lock_ticks = '0;
   endtask

   // Advance the predicted lock by one request and return what it should show afterwards.
   task automatic advance_lock(input bcl_pkg::req_type item, output bcl_pkg::rsp_type view);
      logic [3:0] button_bit;
      button_bit = 4'b0001 << item.button;
      if (item.opcode == bcl_pkg::OP_PRESS) begin
         // Presses count only while entering, and only the first press of each button
         if (lock_mode == bcl_pkg::MODE_ENTER && (lock_mask & button_bit) == 4'b0000) begin
            lock_mask  = lock_mask | button_bit;
            lock_leds  = lock_leds | button_bit;
            lock_entry = lock_entry * 13'd10 + {11'd0, item.button} + 13'd1;
            if (lock_mask == EVERY_BUTTON) begin
               if (lock_entry == cfg_code) begin
                  start_animation(bcl_pkg::MODE_OPEN);
               end else if (lock_mistakes < cfg_retries) begin
                  start_animation(bcl_pkg::MODE_ERROR);
               end else begin
                  start_animation(bcl_pkg::MODE_LOCKED);
               end
            end
         end
      end else if (lock_mode != bcl_pkg::MODE_ENTER) begin
         // A zero period needs no special case: the count is at least one here
         lock_ticks = lock_ticks + 24'd1;
         if (lock_ticks >= cfg_frame_ticks) begin
            lock_ticks = '0;
            if (lock_mode == bcl_pkg::MODE_OPEN) begin
               if (lock_frame > VICTORY_WRAP) lock_frame = '0;
               lock_leds  = VICTORY_SEQ[4*lock_frame +: 4];
               lock_frame = (lock_frame == VICTORY_WRAP) ? 3'd0 : lock_frame + 3'd1;
            end else begin
               lock_leds  = ERROR_SEQ[4*lock_frame +: 4];
               lock_frame = lock_frame + 3'd1;
               if (lock_mode == bcl_pkg::MODE_ERROR) begin
                  lock_shown = lock_shown + 5'd1;
                  // Sixteenth frame: clear the entry within the same request
                  if (lock_shown >= ERROR_FRAME_SHOWS) begin
                     lock_mistakes = lock_mistakes + 2'd1;
                     lock_entry    = '0;
                     lock_mask     = '0;
                     lock_leds     = '0;
                     lock_shown    = '0;
                     lock_frame    = '0;
                     lock_mode     = bcl_pkg::MODE_ENTER;
                  end
               end
            end
         end
      end
      view.leds   = lock_leds;
      view.status = lock_mode;
   endtask

   // Drop valid, but only if it is up, so it never gets two assignments in one step.
   task automatic hold_off();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
   endtask

   task automatic wait_drained();
      while (lock_views.size() != 0) @(posedge clock);
   endtask

   // Send one request, with a random gap before it, and record its predicted view once
   // the block has taken it.
   task automatic send_request(input logic opcode, input logic [1:0] button);
      bcl_pkg::req_type item;
      bcl_pkg::rsp_type view;
      int               gap;
      int               pick;
      item.opcode = opcode;
      item.button = button;
      pick = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if (pick < 4) begin
         burst_left = $urandom_range(20, 60);
         gap = 0;
      end else if (pick < 70) begin
         gap = 0;
      end else if (pick < 95) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(8, 30);
      end
      if (gap > 0) begin
         hold_off();
         repeat (gap) @(posedge clock);
      end
      if (!valid_up) begin
         req_valid <= 1'b1;
         valid_up = 1'b1;
      end
      req_data <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      advance_lock(item, view);
      lock_views.push_back(view);
      sent_count++;
   endtask

   // Write a register with nothing in flight, and mirror it in the prediction.
   task automatic write_csr(input logic [bcl_pkg::CSR_INDEX_W-1:0] index,
                            input logic [bcl_pkg::CSR_DATA_W-1:0] value);
      hold_off();
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         bcl_pkg::CSR_CORRECT_CODE:    cfg_code        = value[bcl_pkg::CODE_W-1:0];
         bcl_pkg::CSR_FRAME_TICKS:     cfg_frame_ticks = value;
         bcl_pkg::CSR_ALLOWED_RETRIES: cfg_retries     = value[bcl_pkg::RETRY_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic shuffle_key_order();
      int          pick;
      logic [1:0]  held;
      for (int i = 0; i < 4; i++) key_order[i] = 2'(i);
      for (int i = 3; i > 0; i--) begin
         pick = $urandom_range(0, i);
         held = key_order[i];
         key_order[i] = key_order[pick];
         key_order[pick] = held;
      end
   endtask

   function automatic logic [12:0] key_code();
      logic [12:0] code;
      code = '0;
      for (int i = 0; i < 4; i++) code = code * 13'd10 + {11'd0, key_order[i]} + 13'd1;
      return code;
   endfunction

   // A code the coming entry cannot match: the range ends, a code no entry reaches,
   // a near miss with the last two digits swapped, or anything else.
   function automatic logic [12:0] pick_wrong_code(input logic [12:0] target);
      logic [12:0] code;
      case ($urandom_range(0, 4))
         0:       code = '0;
         1:       code = CODE_TOP;
         2:       code = CODE_ABOVE_RANGE;
         3:       code = target - target % 13'd100 + (target % 13'd10) * 13'd10
                         + (target / 13'd10) % 13'd10;
         default: code = 13'($urandom_range(0, 8191));
      endcase
      if (code == target) code = code ^ 13'd1;
      return code;
   endfunction

   // Key in the current button order: new buttons in order, mixed with repeat presses
   // and ticks, until the fourth button ends the entry.
   task automatic key_in_entry();
      int next_new;
      int pick;
      next_new = 0;
      while (lock_mode == bcl_pkg::MODE_ENTER) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            send_request(bcl_pkg::OP_TICK, random_button());
         end else if (pick < 45 && next_new > 0) begin
            send_request(bcl_pkg::OP_PRESS, key_order[$urandom_range(0, next_new - 1)]);
         end else begin
            send_request(bcl_pkg::OP_PRESS, key_order[next_new]);
            next_new++;
         end
      end
   endtask

   // Tick through the error animation, with stray presses that must be ignored.
   task automatic ride_error_animation();
      while (lock_mode == bcl_pkg::MODE_ERROR) begin
         if ($urandom_range(0, 99) < 85) send_request(bcl_pkg::OP_TICK, random_button());
         else send_request(bcl_pkg::OP_PRESS, random_button());
      end
   endtask

   // Directed: ticks and repeat presses while entering, register extremes, a wrong
   // entry under a zero frame period, a press during the animation, and the full run
   // of sixteen error frames back to entering.
   task automatic test_directed_entry_and_error();
      write_csr(bcl_pkg::CSR_ALLOWED_RETRIES, {22'd0, 2'd0});
      write_csr(bcl_pkg::CSR_CORRECT_CODE, {11'd0, CODE_ABOVE_RANGE});
      write_csr(bcl_pkg::CSR_FRAME_TICKS, TICKS_MAX);
      send_request(bcl_pkg::OP_TICK, 2'd0);
      send_request(bcl_pkg::OP_PRESS, 2'd3);
      send_request(bcl_pkg::OP_PRESS, 2'd3);
      send_request(bcl_pkg::OP_TICK, 2'd3);
      send_request(bcl_pkg::OP_PRESS, 2'd0);
      write_csr(bcl_pkg::CSR_ALLOWED_RETRIES, {22'd0, 2'd3});
      write_csr(bcl_pkg::CSR_CORRECT_CODE, {11'd0, 13'd0});
      write_csr(bcl_pkg::CSR_FRAME_TICKS, 24'd0);
      send_request(bcl_pkg::OP_PRESS, 2'd2);
      send_request(bcl_pkg::OP_PRESS, 2'd1);
      send_request(bcl_pkg::OP_PRESS, 2'd0);
      repeat (16) send_request(bcl_pkg::OP_TICK, 2'd1);
   endtask

   // One or two more wrong entries. In the first, stretch the frame period to its top
   // mid-animation, then cut it back so the stored count overshoots the new period.
   task automatic test_wrong_entries();
      int          attempts;
      logic [12:0] target;
      attempts = $urandom_range(1, 2);
      for (int n = 0; n < attempts; n++) begin
         shuffle_key_order();
         target = key_code();
         write_csr(bcl_pkg::CSR_CORRECT_CODE, {11'd0, pick_wrong_code(target)});
         write_csr(bcl_pkg::CSR_FRAME_TICKS, (n == 0) ? 24'd3 : 24'($urandom_range(0, 6)));
         key_in_entry();
         if (n == 0) begin
            repeat (5) send_request(bcl_pkg::OP_TICK, random_button());
            write_csr(bcl_pkg::CSR_FRAME_TICKS, TICKS_MAX);
            repeat (10) send_request(bcl_pkg::OP_TICK, random_button());
            write_csr(bcl_pkg::CSR_FRAME_TICKS, 24'd2);
         end
         ride_error_animation();
      end
   endtask

   // Last entry: either the right code, or a wrong one with the retries used up.
   // Both end states are final, so the seed picks which one this run explores.
   task automatic test_final_entry();
      logic [12:0] target;
      shuffle_key_order();
      target = key_code();
      write_csr(bcl_pkg::CSR_FRAME_TICKS, 24'($urandom_range(1, 5)));
      if ($urandom_range(0, 1) == 1) begin
         write_csr(bcl_pkg::CSR_CORRECT_CODE, {11'd0, target});
      end else begin
         write_csr(bcl_pkg::CSR_CORRECT_CODE, {11'd0, pick_wrong_code(target)});
         write_csr(bcl_pkg::CSR_ALLOWED_RETRIES,
                   {22'd0, 2'($urandom_range(0, int'(lock_mistakes)))});
      end
      key_in_entry();
   endtask

   // Loop the final animation under a range of frame periods, one of them the top
   // value, and hold the sender once until every view has come back.
   task automatic test_final_animation();
      int          segment;
      int          length;
      int          pick;
      logic [23:0] period;
      segment = 0;
      while (sent_count < ITEM_TARGET) begin
         pick = $urandom_range(0, 9);
         if (segment == 2) period = TICKS_MAX;
         else if (pick == 0) period = 24'd0;
         else if (pick == 1) period = 24'd1;
         else period = 24'($urandom_range(2, 9));
         write_csr(bcl_pkg::CSR_FRAME_TICKS, period);
         length = (segment == 2) ? 30 : $urandom_range(40, 150);
         for (int k = 0; k < length; k++) begin
            if (segment == 0 && k == length / 2) begin
               hold_off();
               wait_drained();
            end
            if ($urandom_range(0, 99) < 85) send_request(bcl_pkg::OP_TICK, random_button());
            else send_request(bcl_pkg::OP_PRESS, random_button());
         end
         segment++;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_entry_and_error();
      test_wrong_entries();
      test_final_entry();
      test_final_animation();
      // Drain the last views, then leave the block idle so that any stray response shows
      hold_off();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("button_code_lock regression: pass");
      end else begin
         $display("button_code_lock regression: fail");
      end
      $finish;
   end

endmodule
